FILE: rtl/length_framed_topic_deframer_defines.svh
// Assertion macros shared by the deframer RTL.
`ifndef LENGTH_FRAMED_TOPIC_DEFRAMER_DEFINES_SVH
`define LENGTH_FRAMED_TOPIC_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define LFTD_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high
`define LFTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

FILE: rtl/lftd_pkg.sv
// Types and constants for the length-framed topic deframer.
`default_nettype none

package lftd_pkg;

  // Header walker positions: 0..3 sync bytes, 4..7 length bytes, 8 payload
  typedef logic [3:0] hdr_phase_t;
  localparam hdr_phase_t HP_HUNT       = 4'd0;
  localparam hdr_phase_t HP_SYNC_LAST  = 4'd3;
  localparam hdr_phase_t HP_LEN_FIRST  = 4'd4;
  localparam hdr_phase_t HP_LEN_LAST   = 4'd7;
  localparam hdr_phase_t HP_PAYLOAD    = 4'd8;

  localparam logic [7:0] HDR_SYNC = 8'hAA;

  // Handshake magic, followed by four zero bytes
  localparam logic [7:0] HS_MAGIC [4] = '{8'hAA, 8'hBB, 8'hCC, 8'hDD};

  // Payload field walker
  typedef enum logic [2:0] {
    FP_TOPIC_LEN = 3'd0,
    FP_TOPIC     = 3'd1,
    FP_TYPE_LEN  = 3'd2,
    FP_TYPE      = 3'd3,
    FP_DLEN_HI   = 3'd4,
    FP_DLEN_LO   = 3'd5,
    FP_DATA      = 3'd6,
    FP_SURPLUS   = 3'd7
  } field_phase_t;

  typedef enum logic [2:0] {
    CLS_NONE       = 3'd0,
    CLS_TOPIC_LEN  = 3'd1,
    CLS_TOPIC_BYTE = 3'd2,
    CLS_TYPE_LEN   = 3'd3,
    CLS_TYPE_BYTE  = 3'd4,
    CLS_DATA_LEN   = 3'd5,
    CLS_DATA_BYTE  = 3'd6,
    CLS_SURPLUS    = 3'd7
  } byte_class_t;

  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_GOOD      = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_HS_OK     = 3'd3,
    ST_HS_FAIL   = 3'd4,
    ST_LOCKED    = 3'd5
  } status_t;

  // Control state that does not depend on the length width
  typedef struct packed {
    hdr_phase_t   header_phase;
    logic         handshake_pending;
    logic         locked_out;
    logic         len_ovf;
    field_phase_t field_phase;
    logic [15:0]  field_remaining;
  } lftd_ctrl_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
    logic       expect_handshake;
  } lftd_item_t;

  typedef struct packed {
    byte_class_t byte_class;
    logic [7:0]  byte_out;
    logic        frame_end;
    status_t     status;
  } lftd_result_t;

endpackage

`default_nettype wire

FILE: rtl/lftd_if.sv
// Valid/ready channel interfaces for the deframer input and result items.
`default_nettype none

interface lftd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;
  logic       expect_handshake;

  modport source (output valid, kind, byte_value, expect_handshake, input ready);
  modport sink   (input valid, kind, byte_value, expect_handshake, output ready);
endinterface

interface lftd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] byte_class;
  logic [7:0] byte_out;
  logic       frame_end;
  logic [2:0] status;

  modport source (output valid, byte_class, byte_out, frame_end, status, input ready);
  modport sink   (input valid, byte_class, byte_out, frame_end, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/lftd_core.sv
// Next-state and result logic of the deframer for one item.
`default_nettype none

module lftd_core #(
  parameter int LENGTH_BITS = 32
) (
  input  lftd_pkg::lftd_item_t   item,
  input  lftd_pkg::lftd_ctrl_t   ctrl,
  input  logic [LENGTH_BITS-1:0] frame_length,
  input  logic [LENGTH_BITS-1:0] frame_left,
  output lftd_pkg::lftd_ctrl_t   ctrl_next,
  output logic [LENGTH_BITS-1:0] frame_length_next,
  output logic [LENGTH_BITS-1:0] frame_left_next,
  output lftd_pkg::lftd_result_t result
);
  import lftd_pkg::*;

  logic [7:0]             b;
  logic [7:0]             hs_want;
  logic [LENGTH_BITS-1:0] len_base;
  logic                   ovf_base;
  logic [LENGTH_BITS-1:0] len_shift;
  logic                   ovf_shift;
  logic [15:0]            rem_dec;
  logic [15:0]            rem_lo;
  byte_class_t            wf_class;
  field_phase_t           wf_phase;
  logic [15:0]            wf_rem;
  logic                   last_byte;

  assign b = item.byte_value;

  // Expected handshake byte: magic first, then zeros
  assign hs_want = (ctrl.header_phase <= HP_SYNC_LAST) ? HS_MAGIC[ctrl.header_phase[1:0]]
                                                       : 8'h00;

  // Big-endian length accumulation; bits pushed above the width flag oversize
  assign len_base  = (ctrl.header_phase == HP_LEN_FIRST) ? '0 : frame_length;
  assign ovf_base  = (ctrl.header_phase == HP_LEN_FIRST) ? 1'b0 : ctrl.len_ovf;
  assign len_shift = {len_base[LENGTH_BITS-9:0], b};
  assign ovf_shift = ovf_base | (|len_base[LENGTH_BITS-1:LENGTH_BITS-8]);

  assign rem_dec   = ctrl.field_remaining - 16'd1;
  assign rem_lo    = ctrl.field_remaining | {8'h00, b};
  assign last_byte = (frame_left == LENGTH_BITS'(1));

  // Payload field walker
  always_comb begin
    wf_class = CLS_SURPLUS;
    wf_phase = FP_SURPLUS;
    wf_rem   = ctrl.field_remaining;
    unique case (ctrl.field_phase)
      FP_TOPIC_LEN: begin
        wf_class = CLS_TOPIC_LEN;
        wf_rem   = {8'h00, b};
        wf_phase = (b != 8'h00) ? FP_TOPIC : FP_TYPE_LEN;
      end
      FP_TOPIC: begin
        wf_class = CLS_TOPIC_BYTE;
        wf_rem   = rem_dec;
        wf_phase = (rem_dec == 16'd0) ? FP_TYPE_LEN : FP_TOPIC;
      end
      FP_TYPE_LEN: begin
        wf_class = CLS_TYPE_LEN;
        wf_rem   = {8'h00, b};
        wf_phase = (b != 8'h00) ? FP_TYPE : FP_DLEN_HI;
      end
      FP_TYPE: begin
        wf_class = CLS_TYPE_BYTE;
        wf_rem   = rem_dec;
        wf_phase = (rem_dec == 16'd0) ? FP_DLEN_HI : FP_TYPE;
      end
      FP_DLEN_HI: begin
        wf_class = CLS_DATA_LEN;
        wf_rem   = {b, 8'h00};
        wf_phase = FP_DLEN_LO;
      end
      FP_DLEN_LO: begin
        wf_class = CLS_DATA_LEN;
        wf_rem   = rem_lo;
        wf_phase = (rem_lo != 16'd0) ? FP_DATA : FP_SURPLUS;
      end
      FP_DATA: begin
        wf_class = CLS_DATA_BYTE;
        wf_rem   = rem_dec;
        wf_phase = (rem_dec == 16'd0) ? FP_SURPLUS : FP_DATA;
      end
      default: begin
        wf_class = CLS_SURPLUS;
        wf_phase = FP_SURPLUS;
      end
    endcase
  end

  // Main item decode
  always_comb begin
    ctrl_next         = ctrl;
    frame_length_next = frame_length;
    frame_left_next   = frame_left;
    result            = '{byte_class: CLS_NONE, byte_out: b, frame_end: 1'b0,
                          status: ST_BUSY};

    if (item.kind) begin
      // New connection: clear everything
      ctrl_next                   = '0;
      ctrl_next.field_phase       = FP_TOPIC_LEN;
      ctrl_next.handshake_pending = item.expect_handshake;
      frame_length_next           = '0;
      frame_left_next             = '0;
      result.byte_out             = 8'h00;
    end else if (ctrl.locked_out) begin
      result.status = ST_LOCKED;
    end else if (ctrl.handshake_pending) begin
      if (b != hs_want) begin
        ctrl_next.locked_out   = 1'b1;
        ctrl_next.header_phase = HP_HUNT;
        result.frame_end       = 1'b1;
        result.status          = ST_HS_FAIL;
      end else if (ctrl.header_phase >= HP_LEN_LAST) begin
        ctrl_next.handshake_pending = 1'b0;
        ctrl_next.header_phase      = HP_HUNT;
        result.frame_end            = 1'b1;
        result.status               = ST_HS_OK;
      end else begin
        ctrl_next.header_phase = ctrl.header_phase + 4'd1;
      end
    end else if (ctrl.header_phase == HP_HUNT) begin
      if (b == HDR_SYNC) begin
        ctrl_next.header_phase = ctrl.header_phase + 4'd1;
      end
    end else if (ctrl.header_phase <= HP_SYNC_LAST) begin
      // Zero bytes after sync; anything else restarts the hunt
      ctrl_next.header_phase = (b == 8'h00) ? ctrl.header_phase + 4'd1 : HP_HUNT;
    end else if (ctrl.header_phase < HP_LEN_LAST) begin
      frame_length_next      = len_shift;
      ctrl_next.len_ovf      = ovf_shift;
      ctrl_next.header_phase = ctrl.header_phase + 4'd1;
    end else if (ctrl.header_phase == HP_LEN_LAST) begin
      frame_length_next = len_shift;
      ctrl_next.len_ovf = ovf_shift;
      if (ovf_shift || (len_shift == '0)) begin
        // Empty or oversize frame
        ctrl_next.header_phase = HP_HUNT;
        result.frame_end       = 1'b1;
        result.status          = ST_MALFORMED;
      end else begin
        frame_left_next           = len_shift;
        ctrl_next.field_phase     = FP_TOPIC_LEN;
        ctrl_next.field_remaining = 16'd0;
        ctrl_next.header_phase    = HP_PAYLOAD;
      end
    end else begin
      // Payload byte
      result.byte_class = wf_class;
      frame_left_next   = frame_left - LENGTH_BITS'(1);
      if (last_byte) begin
        ctrl_next.header_phase    = HP_HUNT;
        ctrl_next.field_phase     = FP_TOPIC_LEN;
        ctrl_next.field_remaining = 16'd0;
        result.frame_end          = 1'b1;
        result.status             = (wf_phase == FP_SURPLUS) ? ST_GOOD : ST_MALFORMED;
      end else begin
        ctrl_next.field_phase     = wf_phase;
        ctrl_next.field_remaining = wf_rem;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/length_framed_topic_deframer.sv
// Top level of the length-framed topic deframer.
//
// Takes one item per cycle, either a received stream byte or a connection
// start, and returns exactly one result item for each. An item passes an
// input register and then the decode logic into a result register, where
// its result is offered until the output side takes it; a new item is
// accepted every cycle as long as the result register drains, and the block
// stalls only when a finished result is held by the output side. The length
// field is LENGTH_BITS wide; a received length that does not fit in it, or
// a length of zero, is reported as a malformed frame on its last length
// byte.
`default_nettype none
`include "length_framed_topic_deframer_defines.svh"

module length_framed_topic_deframer #(
  parameter int LENGTH_BITS = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  lftd_in_if.sink    in_item,
  lftd_out_if.source out_item
);
  import lftd_pkg::*;

  logic                   s1_valid;
  lftd_item_t             s1_item;
  logic                   out_valid;
  lftd_result_t           out_res;
  logic                   advance;

  lftd_ctrl_t             ctrl;
  lftd_ctrl_t             ctrl_next;
  logic [LENGTH_BITS-1:0] frame_length;
  logic [LENGTH_BITS-1:0] frame_length_next;
  logic [LENGTH_BITS-1:0] frame_left;
  logic [LENGTH_BITS-1:0] frame_left_next;
  lftd_result_t           res_next;

  // Item moves from the input register into the result register
  assign advance      = s1_valid && (!out_valid || out_item.ready);
  assign in_item.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_item.ready) begin
      s1_valid <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      s1_item <= '{kind: in_item.kind, byte_value: in_item.byte_value,
                   expect_handshake: in_item.expect_handshake};
    end
  end

  lftd_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .item              (s1_item),
    .ctrl              (ctrl),
    .frame_length      (frame_length),
    .frame_left        (frame_left),
    .ctrl_next         (ctrl_next),
    .frame_length_next (frame_length_next),
    .frame_left_next   (frame_left_next),
    .result            (res_next)
  );

  // Parser state commits when the item moves on; all-zero is hunting,
  // no handshake, unlocked and expecting the topic length
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (advance) begin
      ctrl <= ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_length <= frame_length_next;
      frame_left   <= frame_left_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign out_item.valid      = out_valid;
  assign out_item.byte_class = out_res.byte_class;
  assign out_item.byte_out   = out_res.byte_out;
  assign out_item.frame_end  = out_res.frame_end;
  assign out_item.status     = out_res.status;

  // Checks
  `LFTD_ASSERT(a_lock_hunts, ctrl.locked_out, ctrl.header_phase == HP_HUNT)
  `LFTD_ASSERT(a_payload_left, ctrl.header_phase == HP_PAYLOAD, frame_left != '0)
  `LFTD_ASSERT_NEXT(a_conn_clears, advance && s1_item.kind,
                    !ctrl.locked_out && (ctrl.header_phase == HP_HUNT))
  `LFTD_ASSERT(a_end_status, out_valid && out_res.frame_end,
               (out_res.status != ST_BUSY) && (out_res.status != ST_LOCKED))

endmodule

`default_nettype wire
